[rtl/golm_pkg.sv]
// ----------------------------------------------------------------------------
// golm_pkg
// Shared types and constants for the glyph outline marker.
// ----------------------------------------------------------------------------
`default_nettype none

package golm_pkg;

    localparam int ROW_W     = 16;
    localparam int MAX_WIDTH = 16;
    localparam int EFF_MAX   = (MAX_WIDTH < ROW_W) ? MAX_WIDTH : ROW_W;
    localparam int WIDTH_W   = 5;
    localparam int PIX_W     = 2;
    localparam int OUT_W     = PIX_W * ROW_W;
    localparam int SHIFT_W   = $clog2(OUT_W + 1);

    localparam logic [PIX_W-1:0] PIX_EMPTY   = 2'd0;
    localparam logic [PIX_W-1:0] PIX_INK     = 2'd1;
    localparam logic [PIX_W-1:0] PIX_OUTLINE = 2'd2;

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [WIDTH_W-1:0] width_t;
    typedef logic [OUT_W-1:0]   pixels_t;

    typedef struct packed {
        row_t above;
        row_t row;
        row_t below;
        logic last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_issue_t;

endpackage

`default_nettype wire

[rtl/golm_in_if.sv]
// ----------------------------------------------------------------------------
// golm_in_if
// Row input channel: one glyph row per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface golm_in_if;
    import golm_pkg::*;

    logic valid;
    logic ready;
    row_t row_bits;
    logic last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

`default_nettype wire

[rtl/golm_out_if.sv]
// ----------------------------------------------------------------------------
// golm_out_if
// Pixel output channel: one rendered row of 2-bit pixels per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface golm_out_if;
    import golm_pkg::*;

    logic    valid;
    logic    ready;
    pixels_t row_pixels;
    logic    last_out;

    modport source (output valid, output row_pixels, output last_out, input ready);
    modport sink   (input valid, input row_pixels, input last_out, output ready);
endinterface

`default_nettype wire

[rtl/golm_window.sv]
// ----------------------------------------------------------------------------
// golm_window
// Row window state and job register: turns each accepted row into up to
// two render jobs and issues them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module golm_window (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire golm_pkg::row_t      in_row,
    input  wire logic                in_last,
    input  wire logic                take,
    output golm_pkg::job_issue_t     issue
);
    import golm_pkg::*;

    row_t upper_reg;
    row_t held_reg;
    logic pending_reg;
    job_t job_a_reg;
    job_t job_b_reg;
    logic job_a_valid_reg;
    logic job_b_valid_reg;

    logic issue_fire;
    logic a_left;
    logic b_left;
    logic in_fire;

    assign issue_fire = (job_a_valid_reg || job_b_valid_reg) && take;
    assign a_left     = job_a_valid_reg && !issue_fire;
    assign b_left     = job_b_valid_reg && !(issue_fire && !job_a_valid_reg);
    assign in_ready   = !a_left && !b_left;
    assign in_fire    = in_valid && in_ready;

    assign issue.valid = job_a_valid_reg || job_b_valid_reg;
    assign issue.job   = job_a_valid_reg ? job_a_reg : job_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg       <= '0;
            held_reg        <= '0;
            pending_reg     <= 1'b0;
            job_a_valid_reg <= 1'b0;
            job_b_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            job_a_valid_reg <= pending_reg;
            job_b_valid_reg <= in_last;
            if (in_last)
            begin
                upper_reg   <= '0;
                held_reg    <= '0;
                pending_reg <= 1'b0;
            end
            else
            begin
                upper_reg   <= pending_reg ? held_reg : '0;
                held_reg    <= in_row;
                pending_reg <= 1'b1;
            end
        end
        else
        begin
            job_a_valid_reg <= a_left;
            job_b_valid_reg <= b_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_a_reg.above <= upper_reg;
            job_a_reg.row   <= held_reg;
            job_a_reg.below <= in_row;
            job_a_reg.last  <= 1'b0;
            job_b_reg.above <= pending_reg ? held_reg : '0;
            job_b_reg.row   <= in_row;
            job_b_reg.below <= '0;
            job_b_reg.last  <= 1'b1;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> !pending_reg)
        else $error("row still held after last row");

    a_pending_job: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pending_reg) |=> job_a_valid_reg)
        else $error("held row not scheduled for output");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!job_a_valid_reg && !job_b_valid_reg) |-> in_ready)
        else $error("not ready with no jobs queued");

endmodule

`default_nettype wire

[rtl/golm_render.sv]
// ----------------------------------------------------------------------------
// golm_render
// Bitwise outline rendering of one row into right-aligned 2-bit pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module golm_render (
    input  wire golm_pkg::job_t     job,
    input  wire golm_pkg::width_t   glyph_width,
    output golm_pkg::pixels_t       pixels
);
    import golm_pkg::*;

    width_t           w;
    row_t             mask;
    row_t             cur;
    row_t             side;
    row_t             edge_bits;
    pixels_t          wide;
    logic [SHIFT_W-1:0] shamt;

    always_comb
    begin
        w = (glyph_width > width_t'(EFF_MAX)) ? width_t'(EFF_MAX) : glyph_width;
        for (int b = 0; b < ROW_W; b++)
        begin
            mask[b] = (WIDTH_W'(ROW_W - 1 - b) < w);
        end
        cur       = job.row & mask;
        side      = (cur << 1) | (cur >> 1);
        edge_bits = (side | (job.above & mask) | (job.below & mask)) & ~cur & mask;
        for (int b = 0; b < ROW_W; b++)
        begin
            if (cur[b])
                wide[PIX_W*b +: PIX_W] = PIX_INK;
            else if (edge_bits[b])
                wide[PIX_W*b +: PIX_W] = PIX_OUTLINE;
            else
                wide[PIX_W*b +: PIX_W] = PIX_EMPTY;
        end
        shamt  = SHIFT_W'(PIX_W) * (SHIFT_W'(ROW_W) - SHIFT_W'(w));
        pixels = wide >> shamt;
    end

endmodule

`default_nettype wire

[rtl/glyph_outline_marker.sv]
// ----------------------------------------------------------------------------
// glyph_outline_marker
// Marks ink and 4-connected outline pixels of a 1-bpp glyph, row by row.
// A row's job is registered when the row below it is accepted, then rendered
// and held in the output register. Throughput: one row per cycle while
// row_out is ready; a last row after a held row has two jobs for one renderer.
// Reset clears the row window and job queue; glyph_width resets to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_outline_marker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    golm_in_if.sink                 row_in,
    golm_out_if.source              row_out,
    input  wire logic               cfg_we,
    input  wire golm_pkg::width_t   cfg_wdata
);
    import golm_pkg::*;

    width_t     width_reg;
    job_issue_t issue;
    pixels_t    pixels;
    pixels_t    pixels_reg;
    logic       last_reg;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || row_out.ready;

    golm_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (row_in.valid),
        .in_ready (row_in.ready),
        .in_row   (row_in.row_bits),
        .in_last  (row_in.last_row),
        .take     (out_free),
        .issue    (issue)
    );

    golm_render u_render (
        .job         (issue.job),
        .glyph_width (width_reg),
        .pixels      (pixels)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= width_t'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                width_reg <= cfg_wdata;
            if (out_free)
                out_valid_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && issue.valid)
        begin
            pixels_reg <= pixels;
            last_reg   <= issue.job.last;
        end
    end

    assign row_out.valid      = out_valid_reg;
    assign row_out.row_pixels = pixels_reg;
    assign row_out.last_out   = last_reg;

endmodule

`default_nettype wire
